[hdl/pmt_pkg.sv]
package pmt_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int CFG_W          = 13;
    localparam int CUR_W          = 13;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd1024;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd768;

    localparam int MIN_SCREEN = 16;
    localparam int OVF_STEP   = 255;
    localparam int Y_MARGIN   = 16;
    localparam int X_BACKOFF  = 8;

    // Header bit positions.
    localparam int HDR_LEFT   = 0;
    localparam int HDR_RIGHT  = 1;
    localparam int HDR_MIDDLE = 2;
    localparam int HDR_MARK   = 3;
    localparam int HDR_XSIGN  = 4;
    localparam int HDR_YSIGN  = 5;
    localparam int HDR_XOVF   = 6;
    localparam int HDR_YOVF   = 7;

    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_HDR = 2'd0,
        PH_X   = 2'd1,
        PH_Y   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] hdr;
        logic [7:0] x_byte;
        logic [7:0] y_byte;
    } t_packet;

    localparam int PKT_W = $bits(t_packet);

endpackage

[hdl/pmt_fifo.sv]
module pmt_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = pmt_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // DEPTH is a power of two, so the pointers wrap on their own.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("item pushed into a full queue");

endmodule

[hdl/pmt_front.sv]
module pmt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    output logic              o_pkt_push,
    output pmt_pkg::t_packet  o_pkt
);

    import pmt_pkg::*;

    t_phase     r_phase;
    t_phase     n_phase;
    logic [7:0] r_hdr;
    logic [7:0] r_xb;
    logic       hdr_load;
    logic       x_load;

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_X: begin
                if (i_accept) begin
                    n_phase = PH_Y;
                end
            end
            PH_Y: begin
                if (i_accept) begin
                    n_phase = PH_HDR;
                end
            end
            default: begin
                // Header phase: a byte without the mark bit is dropped.
                if (i_accept) begin
                    n_phase = i_byte[HDR_MARK] ? PH_X : PH_HDR;
                end
            end
        endcase
    end

    always_comb begin
        hdr_load   = 1'b0;
        x_load     = 1'b0;
        o_pkt_push = 1'b0;
        case (r_phase)
            PH_X: begin
                x_load = i_accept;
            end
            PH_Y: begin
                o_pkt_push = i_accept;
            end
            default: begin
                hdr_load = i_accept && i_byte[HDR_MARK];
            end
        endcase
    end

    assign o_pkt.hdr    = r_hdr;
    assign o_pkt.x_byte = r_xb;
    assign o_pkt.y_byte = i_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hdr_load) begin
            r_hdr <= i_byte;
        end
        if (x_load) begin
            r_xb <= i_byte;
        end
    end

endmodule

[hdl/pmt_back.sv]
module pmt_back #(
    parameter int COORD_BITS = pmt_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_pkt_valid,
    input  pmt_pkg::t_packet             i_pkt,
    output logic                         o_pkt_pop,
    input  logic [pmt_pkg::CFG_W-1:0]    i_width,
    input  logic [pmt_pkg::CFG_W-1:0]    i_height,
    output logic                         o_res_push,
    output logic [2*COORD_BITS+2:0]      o_res,
    input  logic                         i_res_full
);

    import pmt_pkg::*;

    // Signed working width: holds the cursor plus any delta and the screen limit.
    localparam int SW = ((COORD_BITS + 1 > CUR_W + 1) ? COORD_BITS + 1 : CUR_W + 1) + 1;

    localparam logic signed [SW-1:0] TOP_V  = SW'(1 << COORD_BITS);
    localparam logic signed [SW-1:0] MIN_V  = SW'(MIN_SCREEN);
    localparam logic signed [SW-1:0] OVF_V  = SW'(OVF_STEP);
    localparam logic signed [SW-1:0] YMAR_V = SW'(Y_MARGIN);
    localparam logic signed [SW-1:0] XBK_V  = SW'(X_BACKOFF);
    localparam logic signed [SW-1:0] ONE_V  = SW'(1);

    logic [CUR_W-1:0]       r_cur_x;
    logic [CUR_W-1:0]       r_cur_y;
    logic                   go;
    logic [7:0]             hd;
    logic signed [SW-1:0]   w_ext;
    logic signed [SW-1:0]   h_ext;
    logic signed [SW-1:0]   w_lim;
    logic signed [SW-1:0]   h_lim;
    logic signed [SW-1:0]   cur_x_ext;
    logic signed [SW-1:0]   cur_y_ext;
    logic signed [SW-1:0]   dx;
    logic signed [SW-1:0]   dy;
    logic signed [SW-1:0]   x_sum;
    logic signed [SW-1:0]   y_sum;
    logic signed [SW-1:0]   x_pos;
    logic signed [SW-1:0]   y_pos;
    logic signed [SW-1:0]   x_new;
    logic signed [SW-1:0]   y_new;
    logic [SW-1:0]          x_out;
    logic [SW-1:0]          y_out;
    logic                   left;
    logic                   middle;
    logic                   right;

    assign go         = i_pkt_valid && !i_res_full;
    assign o_pkt_pop  = go;
    assign o_res_push = go;
    assign hd         = i_pkt.hdr;

    assign w_ext     = signed'({{(SW-CFG_W){1'b0}}, i_width});
    assign h_ext     = signed'({{(SW-CFG_W){1'b0}}, i_height});
    assign cur_x_ext = signed'({{(SW-CUR_W){1'b0}}, r_cur_x});
    assign cur_y_ext = signed'({{(SW-CUR_W){1'b0}}, r_cur_y});

    always_comb begin
        w_lim = w_ext;
        if (w_ext < MIN_V) begin
            w_lim = MIN_V;
        end else if (w_ext > TOP_V) begin
            w_lim = TOP_V;
        end
        h_lim = h_ext;
        if (h_ext < MIN_V) begin
            h_lim = MIN_V;
        end else if (h_ext > TOP_V) begin
            h_lim = TOP_V;
        end
    end

    // Nine-bit signed deltas; an overflow bit pushes a further step along the sign.
    always_comb begin
        dx = signed'({{(SW-8){hd[HDR_XSIGN]}}, i_pkt.x_byte});
        if (hd[HDR_XOVF]) begin
            dx = hd[HDR_XSIGN] ? dx - OVF_V : dx + OVF_V;
        end
        dy = -signed'({{(SW-8){hd[HDR_YSIGN]}}, i_pkt.y_byte});
        if (hd[HDR_YOVF]) begin
            dy = hd[HDR_YSIGN] ? dy + OVF_V : dy - OVF_V;
        end
    end

    assign x_sum = cur_x_ext + dx;
    assign y_sum = cur_y_ext + dy;

    always_comb begin
        x_pos = (x_sum < 0) ? '0 : x_sum;
        x_new = (x_pos > w_lim - ONE_V) ? w_lim - XBK_V : x_pos;
        y_pos = (y_sum < 0) ? '0 : y_sum;
        y_new = (y_pos > h_lim - YMAR_V) ? h_lim - YMAR_V : y_pos;
    end

    assign x_out = {{(SW-CUR_W){1'b0}}, x_new[CUR_W-1:0]};
    assign y_out = {{(SW-CUR_W){1'b0}}, y_new[CUR_W-1:0]};

    assign left   = hd[HDR_LEFT];
    assign middle = !hd[HDR_LEFT] && hd[HDR_MIDDLE];
    assign right  = !hd[HDR_LEFT] && !hd[HDR_MIDDLE] && hd[HDR_RIGHT];

    assign o_res = {x_out[COORD_BITS-1:0], y_out[COORD_BITS-1:0], left, middle, right};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= '0;
            r_cur_y <= '0;
        end else if (go) begin
            r_cur_x <= x_new[CUR_W-1:0];
            r_cur_y <= y_new[CUR_W-1:0];
        end
    end

    a_x_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |=> cur_x_ext <= $past(w_lim) - ONE_V)
        else $error("cursor X left the screen after a packet");

    a_y_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |=> cur_y_ext <= $past(h_lim) - YMAR_V)
        else $error("cursor Y left the screen after a packet");

endmodule

[hdl/ps2_mouse_packet_tracker.sv]
// PS/2 mouse packet tracker.
// Input channel: raw mouse bytes on i_data_byte, taken when push is high and
// full is low. Three bytes make a packet: a header (bit 3 set, otherwise the
// byte is dropped), an X byte and a Y byte. Each packet gives one result.
// Result channel: the oldest result sits on o_pos_x, o_pos_y and the button
// outputs while empty is low, and is taken when pop is high.
// Configuration: i_cfg_we writes i_cfg_data into the register that i_cfg_idx
// selects (screen width, screen height); write only while the block is idle.
// Throughput is one byte per cycle while full is low. On the third byte the
// front assembler writes its packet into a two-entry packet queue; the
// cursor update drains one packet per cycle while the result queue has room
// into a two-entry result queue, where the result appears, so a byte every
// cycle keeps flowing while pop is high. When pop stays low the result queue
// fills, the cursor update stops, the packet queue fills and full rises.
// Reset (synchronous, active low) empties both queues, puts the cursor at
// the origin, waits for a header byte and restores 1024 by 768.
module ps2_mouse_packet_tracker #(
    parameter int COORD_BITS = pmt_pkg::COORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [7:0]                 i_data_byte,
    output logic                       empty,
    input  logic                       pop,
    output logic [COORD_BITS-1:0]      o_pos_x,
    output logic [COORD_BITS-1:0]      o_pos_y,
    output logic                       o_left_pressed,
    output logic                       o_middle_pressed,
    output logic                       o_right_pressed,
    input  logic                       i_cfg_we,
    input  pmt_pkg::t_cfg_idx          i_cfg_idx,
    input  logic [pmt_pkg::CFG_W-1:0]  i_cfg_data
);

    import pmt_pkg::*;

    localparam int RES_W = 2 * COORD_BITS + 3;

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic             accept;
    logic             pkt_push;
    t_packet          pkt_in;
    t_packet          pkt_head;
    logic [PKT_W-1:0] pkt_head_bits;
    logic             pkt_empty;
    logic             pkt_pop;
    logic             res_push;
    logic             res_full;
    logic [RES_W-1:0] res_in;
    logic [RES_W-1:0] res_head;

    assign accept   = push && !full;
    assign pkt_head = t_packet'(pkt_head_bits);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default:    r_width  <= r_width;
            endcase
        end
    end

    pmt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_byte     (i_data_byte),
        .o_pkt_push (pkt_push),
        .o_pkt      (pkt_in)
    );

    pmt_fifo #(
        .W     (PKT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_pkt_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (pkt_push),
        .i_data  (pkt_in),
        .o_full  (full),
        .i_pop   (pkt_pop),
        .o_data  (pkt_head_bits),
        .o_empty (pkt_empty)
    );

    pmt_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pkt_valid (!pkt_empty),
        .i_pkt       (pkt_head),
        .o_pkt_pop   (pkt_pop),
        .i_width     (r_width),
        .i_height    (r_height),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full)
    );

    pmt_fifo #(
        .W     (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_head),
        .o_empty (empty)
    );

    assign o_pos_x          = res_head[RES_W-1 -: COORD_BITS];
    assign o_pos_y          = res_head[COORD_BITS+2 -: COORD_BITS];
    assign o_left_pressed   = res_head[2];
    assign o_middle_pressed = res_head[1];
    assign o_right_pressed  = res_head[0];

endmodule
